>>> rtl/assert_macros.svh
// Assertion macros used by the checker of the dither block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on the same clock edge as its trigger.
`define FSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold on the clock edge after its trigger.
`define FSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fsd_pkg.sv
// Constants and register codes shared by the Floyd-Steinberg dither files.
package fsd_pkg;

    // Widest image row held in the error line memory.
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // Field and register widths.
    localparam int PIX_W      = 8;
    localparam int LW_W       = 11;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Width able to hold both the register value and MAX_WIDTH.
    localparam int CNT_W = (LW_W > COL_W + 1) ? LW_W : COL_W + 1;

    // Error arithmetic in sixteenths of a grey step, but for V_W and E_W, which are in whole grey steps.
    localparam int ERR_W = 14;
    localparam int RC_W  = 13;
    localparam int E_W   = 10;
    localparam int SUM_W = 17;
    localparam int V_W   = SUM_W - 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b1;

    // Register reset values.
    localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 11'd1024;
    localparam logic [THR_W-1:0] THRESHOLD_RST  = 8'd128;

    // Output levels.
    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

endpackage

>>> rtl/fsd_err_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module fsd_err_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 14,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; returns the contents from before a write on the same edge.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/floyd_steinberg_dither_unit.sv
// Floyd-Steinberg error diffusion ditherer: grey pixels in, black or white pixels out.
//
//   Channel   Direction  Payload
//   s_*       in         tdata[7:0] pixel_value, tuser frame_start
//   m_*       out        tdata[7:0] dither_value (0 or 255)
//   cfg_*     in         index 0 line_width (11 bits), index 1 threshold (8 bits)
//
// One pixel per clock sustained while m_* is not stalled; a taken beat passes the diffusion stage
// register and then the output register to m_*. The loop that sets the rate is the error update
// of the diffusion stage: its right-hand carry is registered and feeds the next pixel.
// The error line memory is read as a pixel is taken; a write on the same edge is forwarded.
// Reset needs no clearing pass: a fill count marks unwritten columns, which read as zero.
// A stalled m_* side holds the result and the diffusion stage, and s_tready then falls.
module floyd_steinberg_dither_unit
    import fsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel_value
    input  logic                  s_tuser,   // [0] frame_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,   // [7:0] dither_value
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic [LW_W-1:0]  line_width_reg;
    logic [THR_W-1:0] threshold_reg;

    // Raster position.
    logic [COL_W-1:0] column_count_reg;
    logic             in_first_row_reg;

    // Diffusion stage.
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic             s1_fs_reg;
    logic             s1_first_reg;
    logic             s1_last_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             fwd_hit_reg;
    logic [ERR_W-1:0] fwd_data_reg;
    logic             rd_zero_reg;

    // Carried errors.
    logic signed [RC_W-1:0]  right_carry_reg;
    logic signed [ERR_W-1:0] below_reg;
    logic signed [ERR_W-1:0] below_left_reg;

    // Deferred write of the last column of a row.
    logic             dfr_valid_reg;
    logic [COL_W-1:0] dfr_addr_reg;
    logic [ERR_W-1:0] dfr_data_reg;

    // Columns written since reset form the prefix below this count.
    logic [COL_W:0] fill_reg;

    // Output register.
    logic out_valid_reg;
    logic out_white_reg;

    // Handshake.
    logic in_accept;
    logic s1_fire;

    // Column selection.
    logic [CNT_W-1:0] lw_ext;
    logic [CNT_W-1:0] w_eff;
    logic [COL_W-1:0] last_col;
    logic [COL_W-1:0] cc;
    logic [COL_W-1:0] c0;
    logic             last0;
    logic             first0;

    // Error arithmetic.
    logic signed [RC_W-1:0]  rc_eff;
    logic signed [ERR_W-1:0] bp_eff;
    logic signed [ERR_W-1:0] blp_eff;
    logic signed [ERR_W-1:0] line_err;
    logic [ERR_W-1:0]        ram_rd_data;
    logic signed [SUM_W-1:0] sum;
    logic signed [V_W-1:0]   v_s;
    logic                    white;
    logic signed [E_W-1:0]   e_s;
    logic signed [ERR_W-1:0] e_x;
    logic signed [ERR_W-1:0] e3;
    logic signed [ERR_W-1:0] e5;
    logic signed [RC_W-1:0]  e7;
    logic signed [ERR_W-1:0] left_wr;
    logic signed [ERR_W-1:0] own_wr;

    // Memory write port.
    logic             ram_wr_en;
    logic [COL_W-1:0] ram_wr_addr;
    logic [ERR_W-1:0] ram_wr_data;

    // Handshake: the diffusion stage moves on whenever the output register frees up.
    assign in_accept = s_tvalid && s_tready;
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || s1_fire;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_white_reg ? PIX_WHITE : '0;

    // Column of the incoming pixel, with the width clamped to between 1 and the memory depth.
    always_comb
    begin
        lw_ext = CNT_W'(line_width_reg);
        if (line_width_reg == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (lw_ext > CNT_W'(MAX_WIDTH))
        begin
            w_eff = CNT_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = lw_ext;
        end
        last_col = COL_W'(w_eff - CNT_W'(1));
        cc       = s_tuser ? '0 : column_count_reg;
        c0       = (cc >= last_col) ? last_col : cc;
        last0    = (c0 == last_col);
        first0   = s_tuser || in_first_row_reg;
    end

    // Corrected value, threshold decision and the four error shares.
    always_comb
    begin
        rc_eff  = s1_fs_reg ? '0 : right_carry_reg;
        bp_eff  = s1_fs_reg ? '0 : below_reg;
        blp_eff = s1_fs_reg ? '0 : below_left_reg;
        if (fwd_hit_reg)
        begin
            line_err = $signed(fwd_data_reg);
        end
        else if (rd_zero_reg || s1_first_reg)
        begin
            line_err = '0;
        end
        else
        begin
            line_err = $signed(ram_rd_data);
        end
        if (s1_first_reg)
        begin
            line_err = '0;
        end
        sum   = $signed({1'b0, s1_pixel_reg, 4'b0000}) + SUM_W'(rc_eff)
              + SUM_W'(line_err) + SUM_W'(8);
        v_s   = $signed(sum[SUM_W-1:4]);
        white = (v_s >= $signed({{(V_W-THR_W){1'b0}}, threshold_reg}));
        e_s   = white ? E_W'(v_s - V_W'(255)) : E_W'(v_s);
        e_x   = ERR_W'(e_s);
        e3    = e_x + (e_x <<< 1);
        e5    = e_x + (e_x <<< 2);
        e7    = RC_W'((e_x <<< 3) - e_x);
        left_wr = blp_eff + e3;
        own_wr  = bp_eff + e5;
    end

    // Write port: deferred last column, else left column, else column 0 of a one-column row.
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = '0;
        if (dfr_valid_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = dfr_addr_reg;
            ram_wr_data = dfr_data_reg;
        end
        else if (s1_fire && (s1_col_reg != '0))
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = s1_col_reg - COL_W'(1);
            ram_wr_data = left_wr;
        end
        else if (s1_fire && s1_last_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = s1_col_reg;
            ram_wr_data = own_wr;
        end
    end

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Error line memory.
    fsd_err_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (ERR_W)
    ) u_err_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_accept),
        .rd_addr (c0),
        .rd_data (ram_rd_data)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RST;
            threshold_reg  <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_WIDTH: line_width_reg <= cfg_data[LW_W-1:0];
                CFG_THRESHOLD:  threshold_reg  <= cfg_data[THR_W-1:0];
                default:        ;
            endcase
        end
    end

    // Raster position and stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            in_first_row_reg <= 1'b1;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            dfr_valid_reg    <= 1'b0;
            fill_reg         <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (in_accept)
            begin
                if (last0)
                begin
                    column_count_reg <= '0;
                    in_first_row_reg <= 1'b0;
                end
                else
                begin
                    column_count_reg <= c0 + COL_W'(1);
                    in_first_row_reg <= first0;
                end
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            dfr_valid_reg <= s1_fire && s1_last_reg && (s1_col_reg != '0);
            if (ram_wr_en && ({1'b0, ram_wr_addr} >= fill_reg))
            begin
                fill_reg <= {1'b0, ram_wr_addr} + (COL_W+1)'(1);
            end
        end
    end

    // Error carries between neighbouring pixels.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_carry_reg <= '0;
            below_reg       <= '0;
            below_left_reg  <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                right_carry_reg <= '0;
                below_reg       <= '0;
                below_left_reg  <= '0;
            end
            else
            begin
                right_carry_reg <= e7;
                below_reg       <= e_x;
                below_left_reg  <= own_wr;
            end
        end
    end

    // Payload of the diffusion stage, the forwarded memory word and the result.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= s_tdata;
            s1_fs_reg    <= s_tuser;
            s1_first_reg <= first0;
            s1_last_reg  <= last0;
            s1_col_reg   <= c0;
            fwd_hit_reg  <= ram_wr_en && (ram_wr_addr == c0);
            fwd_data_reg <= ram_wr_data;
            rd_zero_reg  <= ({1'b0, c0} >= fill_reg);
        end
        if (s1_fire)
        begin
            out_white_reg <= white;
            dfr_addr_reg  <= s1_col_reg;
            dfr_data_reg  <= own_wr;
        end
    end

endmodule

>>> rtl/fsd_checker.sv
// Port-level checker for the dither block, bound to its top level.
`include "assert_macros.svh"

module fsd_checker
    import fsd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [PIX_W-1:0] m_tdata
);

    // Every result is pure black or pure white.
    `FSD_ASSERT_IMP(a_binary_out, m_tvalid, (m_tdata == '0) || (m_tdata == PIX_WHITE), "output pixel is neither black nor white")

    // A taken pixel, or one before it, reaches the output through the diffusion stage and the output register.
    `FSD_ASSERT_IMP(a_latency, s_tvalid && s_tready, ##2 m_tvalid, "no result two cycles after an input beat")

    // With the output register empty nothing holds the input side back.
    `FSD_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready, "input stalled while the output is empty")

    // A stalled result stays put.
    `FSD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output beat changed")

endmodule

bind floyd_steinberg_dither_unit fsd_checker u_fsd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
